FILE: design/vomt_pkg.sv
// ----------------------------------------------------------------------------
// vomt_pkg
// Types and constants shared by the object motion table modules.
// ----------------------------------------------------------------------------
package vomt_pkg;

	typedef enum logic [3:0] {
		CMD_TICK   = 4'd0,
		CMD_PLACE  = 4'd1,
		CMD_RESET  = 4'd2,
		CMD_ENABLE = 4'd3,
		CMD_SPEEDS = 4'd4,
		CMD_SPIN   = 4'd5,
		CMD_GROW   = 4'd6,
		CMD_STOP   = 4'd7,
		CMD_INIT   = 4'd8,
		CMD_CLEAR  = 4'd9
	} cmd_t;

	localparam logic [1:0] REG_ACTIVE_COUNT = 2'd0;
	localparam logic [1:0] REG_CENTER_X     = 2'd1;
	localparam logic [1:0] REG_CENTER_Y     = 2'd2;

	localparam int ID_W = 6;
	localparam logic [7:0] UNITY_SCALE = 8'h80;
	localparam int QUEUE_DEPTH = 2;

	// Decoded command as it travels from the front end to the back end.
	typedef struct packed {
		cmd_t            cmd;
		logic [ID_W-1:0] id;
		logic [15:0]     x;
		logic [15:0]     y;
		logic [9:0]      angle;
		logic [7:0]      scale;
		logic [7:0]      sp0;
		logic [7:0]      sp1;
	} op_t;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [9:0]  rot;
		logic [7:0]  scale;
		logic        shown;
	} pose_t;

	typedef struct packed {
		logic [7:0] mx;
		logic [7:0] my;
		logic [7:0] spin;
		logic [7:0] grow;
	} speed_set_t;

	localparam int POSE_W = $bits(pose_t);
	localparam int MOTION_W = $bits(speed_set_t);

endpackage

FILE: design/vomt_in_if.sv
// ----------------------------------------------------------------------------
// vomt_in_if
// Command channel of the object motion table.
// ----------------------------------------------------------------------------
interface vomt_in_if;
	logic               valid;
	logic               ready;
	logic [3:0]         command;
	logic [5:0]         symbol_id;
	logic [15:0]        tick_value;
	logic [15:0]        x_pos;
	logic [15:0]        y_pos;
	logic [9:0]         angle;
	logic [7:0]         scale_value;
	logic signed [7:0]  speed_x;
	logic signed [7:0]  speed_y;
	logic signed [7:0]  spin_speed;
	logic signed [7:0]  grow_speed;

	modport source (
		output valid, command, symbol_id, tick_value, x_pos, y_pos, angle,
		       scale_value, speed_x, speed_y, spin_speed, grow_speed,
		input  ready
	);
	modport sink (
		input  valid, command, symbol_id, tick_value, x_pos, y_pos, angle,
		       scale_value, speed_x, speed_y, spin_speed, grow_speed,
		output ready
	);
endinterface

FILE: design/vomt_out_if.sv
// ----------------------------------------------------------------------------
// vomt_out_if
// Object report channel of the object motion table.
// ----------------------------------------------------------------------------
interface vomt_out_if;
	logic        valid;
	logic        ready;
	logic [5:0]  object_index;
	logic [15:0] out_x;
	logic [15:0] out_y;
	logic [9:0]  out_rotation;
	logic [7:0]  out_scale;
	logic        out_visible;
	logic        last_of_run;

	modport source (
		output valid, object_index, out_x, out_y, out_rotation, out_scale,
		       out_visible, last_of_run,
		input  ready
	);
	modport sink (
		input  valid, object_index, out_x, out_y, out_rotation, out_scale,
		       out_visible, last_of_run,
		output ready
	);
endinterface

FILE: design/vomt_cfg_if.sv
// ----------------------------------------------------------------------------
// vomt_cfg_if
// Register write channel of the object motion table.
// ----------------------------------------------------------------------------
interface vomt_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: design/vomt_ram.sv
// ----------------------------------------------------------------------------
// vomt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module vomt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: design/vomt_front.sv
// ----------------------------------------------------------------------------
// vomt_front
// Accepts command words and register writes, drops commands that have no
// effect, and hands the rest to the back end as decoded operations.
// ----------------------------------------------------------------------------
module vomt_front #(
	parameter int TABLE_SIZE = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	vomt_in_if.sink         item,
	vomt_cfg_if.sink        cfg,
	output logic            push_valid,
	input  logic            push_ready,
	output vomt_pkg::op_t   push_data
);
	import vomt_pkg::*;

	localparam logic [6:0] TS7 = 7'(TABLE_SIZE);

	logic [6:0]  active_count_q;
	logic [15:0] center_x_q;
	logic [15:0] center_y_q;
	logic [7:0]  prev_tick_q;

	cmd_t       cmd;
	logic       accept;
	logic       tick_new;
	logic       id_ok;
	logic       keep;
	logic [6:0] run_len;
	logic [6:0] last_idx;

	assign cfg.ready = 1'b1;
	assign item.ready = push_ready;
	assign accept = item.valid && item.ready;
	assign cmd = cmd_t'(item.command);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_count_q <= '0;
			center_x_q <= '0;
			center_y_q <= '0;
			prev_tick_q <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_ACTIVE_COUNT: active_count_q <= cfg.data[6:0];
					REG_CENTER_X:     center_x_q <= cfg.data;
					REG_CENTER_Y:     center_y_q <= cfg.data;
					default: ;
				endcase
			end
			if (accept && cmd == CMD_TICK && tick_new) begin
				prev_tick_q <= item.tick_value[7:0];
			end
		end
	end

	always_comb begin
		tick_new = item.tick_value[7:0] != prev_tick_q;
		id_ok = {1'b0, item.symbol_id} < TS7;
		run_len = (active_count_q > TS7) ? TS7 : active_count_q;
		last_idx = run_len - 7'd1;

		case (cmd)
			CMD_TICK:  keep = tick_new && (run_len != 7'd0);
			CMD_CLEAR: keep = 1'b1;
			CMD_PLACE, CMD_RESET, CMD_ENABLE, CMD_SPEEDS, CMD_SPIN, CMD_GROW,
			CMD_STOP, CMD_INIT: keep = id_ok;
			default:   keep = 1'b0;
		endcase

		push_data.cmd = cmd;
		// A tick carries the index of the last entry of its run.
		push_data.id = (cmd == CMD_TICK) ? last_idx[ID_W-1:0] : item.symbol_id;
		push_data.x = (cmd == CMD_INIT) ? center_x_q : item.x_pos;
		push_data.y = (cmd == CMD_INIT) ? center_y_q : item.y_pos;
		push_data.angle = item.angle;
		push_data.scale = item.scale_value;
		case (cmd)
			CMD_SPEEDS: push_data.sp0 = item.speed_x;
			CMD_SPIN:   push_data.sp0 = item.spin_speed;
			default:    push_data.sp0 = item.grow_speed;
		endcase
		push_data.sp1 = item.speed_y;
	end

	assign push_valid = accept && keep;
endmodule

FILE: design/vomt_queue.sv
// ----------------------------------------------------------------------------
// vomt_queue
// Short first-in first-out queue of decoded operations.
// ----------------------------------------------------------------------------
module vomt_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  vomt_pkg::op_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output vomt_pkg::op_t pop_data
);
	import vomt_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	op_t           entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = count_q != CW'(QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_data = entry_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

FILE: design/vomt_back.sv
// ----------------------------------------------------------------------------
// vomt_back
// Executes decoded operations against the object table and walks the
// table on a tick, one entry per cycle while the report is not stalled, into the report register.
// ----------------------------------------------------------------------------
module vomt_back #(
	parameter int TABLE_SIZE = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  vomt_pkg::op_t pop_data,
	vomt_out_if.source    result
);
	import vomt_pkg::*;

	localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

	typedef enum logic {S_IDLE, S_EXEC} state_t;

	state_t                state_q;
	op_t                   op_q;
	logic [IDX_W-1:0]      cnt_q;
	logic [TABLE_SIZE-1:0] pose_vld_q;
	logic [TABLE_SIZE-1:0] mot_vld_q;
	logic                  pose_ok_q;
	logic                  mot_ok_q;

	logic                  res_valid_q;
	logic [IDX_W-1:0]      res_idx_q;
	pose_t                 res_pose_q;
	logic                  res_last_q;

	logic                  rd_en;
	logic [IDX_W-1:0]      rd_addr;
	logic [POSE_W-1:0]     pose_rd;
	logic [MOTION_W-1:0]   mot_rd;
	pose_t                 cur_pose;
	speed_set_t            cur_mot;
	pose_t                 adv_pose;
	pose_t                 new_pose;
	speed_set_t            new_mot;
	logic                  pose_we;
	logic                  mot_we;
	logic                  is_tick;
	logic                  fire;
	logic                  at_last;
	logic                  res_load;
	logic [7:0]            grown;

	assign is_tick = op_q.cmd == CMD_TICK;
	assign fire = !res_valid_q || result.ready;
	assign at_last = cnt_q == op_q.id[IDX_W-1:0];
	assign res_load = state_q == S_EXEC && is_tick && fire;
	assign pop_ready = state_q == S_IDLE;

	// Entries never written since reset read as zero, and so does motion that was cleared.
	assign cur_pose = pose_ok_q ? pose_t'(pose_rd) : '0;
	assign cur_mot = mot_ok_q ? speed_set_t'(mot_rd) : '0;

	always_comb begin
		rd_en = 1'b0;
		rd_addr = IDX_W'(cnt_q + 1'b1);
		if (state_q == S_IDLE && pop_valid && pop_data.cmd != CMD_CLEAR) begin
			rd_en = 1'b1;
			rd_addr = (pop_data.cmd == CMD_TICK) ? '0 : pop_data.id[IDX_W-1:0];
		end else if (res_load && !at_last) begin
			rd_en = 1'b1;
		end
	end

	// One tick step of a shown object.
	always_comb begin
		adv_pose = cur_pose;
		grown = cur_pose.scale + cur_mot.grow;
		if (cur_pose.shown) begin
			adv_pose.rot = cur_pose.rot + {{2{cur_mot.spin[7]}}, cur_mot.spin};
			adv_pose.x = cur_pose.x + {{8{cur_mot.mx[7]}}, cur_mot.mx};
			adv_pose.y = cur_pose.y + {{8{cur_mot.my[7]}}, cur_mot.my};
			if (cur_mot.grow != '0) begin
				adv_pose.scale = grown;
				if ((!cur_mot.grow[7] && grown < cur_pose.scale) ||
				    (cur_mot.grow[7] && grown > cur_pose.scale)) begin
					adv_pose.shown = 1'b0;
				end
			end
		end
	end

	always_comb begin
		new_pose = cur_pose;
		new_mot = cur_mot;
		pose_we = 1'b0;
		mot_we = 1'b0;
		if (state_q == S_EXEC) begin
			case (op_q.cmd)
				CMD_TICK: begin
					new_pose = adv_pose;
					pose_we = fire;
				end
				CMD_PLACE, CMD_RESET, CMD_ENABLE: begin
					new_pose.x = op_q.x;
					new_pose.y = op_q.y;
					new_pose.rot = op_q.angle;
					if (op_q.cmd == CMD_PLACE || op_q.scale != '0) begin
						new_pose.scale = op_q.scale;
					end
					if (op_q.cmd != CMD_RESET) begin
						new_pose.shown = 1'b1;
					end
					pose_we = 1'b1;
				end
				CMD_INIT: begin
					new_pose.x = op_q.x;
					new_pose.y = op_q.y;
					new_pose.rot = '0;
					new_pose.scale = UNITY_SCALE;
					new_pose.shown = 1'b0;
					pose_we = 1'b1;
				end
				CMD_SPEEDS: begin
					new_mot.mx = op_q.sp0;
					new_mot.my = op_q.sp1;
					mot_we = 1'b1;
				end
				CMD_SPIN: begin
					new_mot.spin = op_q.sp0;
					mot_we = 1'b1;
				end
				CMD_GROW: begin
					new_mot.grow = op_q.sp0;
					mot_we = 1'b1;
				end
				CMD_STOP: begin
					new_mot = '0;
					mot_we = 1'b1;
				end
				default: ;
			endcase
		end
	end

	vomt_ram #(.WIDTH(POSE_W), .DEPTH(TABLE_SIZE), .AW(IDX_W)) u_pose_ram (
		.clk   (clk),
		.we    (pose_we),
		.waddr (cnt_q),
		.wdata (new_pose),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (pose_rd)
	);

	vomt_ram #(.WIDTH(MOTION_W), .DEPTH(TABLE_SIZE), .AW(IDX_W)) u_motion_ram (
		.clk   (clk),
		.we    (mot_we),
		.waddr (cnt_q),
		.wdata (new_mot),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (mot_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= '0;
			cnt_q <= '0;
			pose_vld_q <= '0;
			mot_vld_q <= '0;
			pose_ok_q <= 1'b0;
			mot_ok_q <= 1'b0;
			res_valid_q <= 1'b0;
			res_idx_q <= '0;
			res_pose_q <= '0;
			res_last_q <= 1'b0;
		end else begin
			if (rd_en) begin
				pose_ok_q <= pose_vld_q[rd_addr];
				mot_ok_q <= mot_vld_q[rd_addr];
			end
			if (pose_we) begin
				pose_vld_q[cnt_q] <= 1'b1;
			end
			if (mot_we) begin
				mot_vld_q[cnt_q] <= 1'b1;
			end

			if (res_load) begin
				res_valid_q <= 1'b1;
				res_idx_q <= cnt_q;
				res_pose_q <= adv_pose;
				res_last_q <= at_last;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (pop_valid) begin
						op_q <= pop_data;
						if (pop_data.cmd == CMD_CLEAR) begin
							mot_vld_q <= '0;
						end else begin
							state_q <= S_EXEC;
							cnt_q <= (pop_data.cmd == CMD_TICK) ? '0 :
							         pop_data.id[IDX_W-1:0];
						end
					end
				end
				S_EXEC: begin
					if (!is_tick) begin
						state_q <= S_IDLE;
					end else if (fire) begin
						if (at_last) begin
							state_q <= S_IDLE;
						end else begin
							cnt_q <= IDX_W'(cnt_q + 1'b1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid = res_valid_q;
	assign result.object_index = ID_W'(res_idx_q);
	assign result.out_x = res_pose_q.x;
	assign result.out_y = res_pose_q.y;
	assign result.out_rotation = res_pose_q.rot;
	assign result.out_scale = res_pose_q.scale;
	assign result.out_visible = res_pose_q.shown;
	assign result.last_of_run = res_last_q;

`ifndef SYNTHESIS
	a_report_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !$past(result.valid) |-> $past(state_q == S_EXEC && is_tick))
		else $error("report word appeared outside a tick walk");

	a_last_matches_run: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> result.last_of_run == $past(at_last))
		else $error("last marker does not match the end of the run");

	a_no_read_write_clash: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en && (pose_we || mot_we) |-> rd_addr != cnt_q)
		else $error("table read and write hit the same entry");
`endif
endmodule

FILE: design/vector_object_motion_table.sv
// ----------------------------------------------------------------------------
// vector_object_motion_table
// Table of display objects with per-object motion, updated on system ticks.
// ----------------------------------------------------------------------------
// The front end takes one command word per cycle while its two-entry queue
// has room; repeated ticks and commands to objects outside the table are
// dropped there, and clear motion is done by the back end in its idle state
// without a table access. Any other command reads and then writes one table
// entry. A tick walks n = min(active_count, TABLE_SIZE) entries, reading
// one entry per cycle through the single read port of the table RAMs, and
// gives one report word per entry; a stalled report holds the walk. Reset
// makes every object zero and hidden at once; there is no clearing pass.
module vector_object_motion_table #(
	parameter int TABLE_SIZE = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	vomt_in_if.sink     item,
	vomt_out_if.source  result,
	vomt_cfg_if.sink    cfg
);
	import vomt_pkg::*;

	logic push_valid;
	logic push_ready;
	op_t  push_data;
	logic pop_valid;
	logic pop_ready;
	op_t  pop_data;

	vomt_front #(.TABLE_SIZE(TABLE_SIZE)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	vomt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	vomt_back #(.TABLE_SIZE(TABLE_SIZE)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.result    (result)
	);
endmodule
